/* design/wsi_pkg.sv */
`default_nettype none
package wsi_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_TOTAL_TIME    = 2'd0;
  localparam logic [1:0] REG_POINTS_IN_USE = 2'd1;
  localparam logic [1:0] REG_JOINTS_IN_USE = 2'd2;

  localparam int WGT_W  = 26;

  typedef struct packed {
    opcode_t            op;
    logic [9:0]         point;
    logic [2:0]         joint;
    logic signed [31:0] value;
    logic               zero;
    logic               past_end;
  } item_t;

endpackage
`default_nettype wire

/* design/wsi_in_if.sv */
`default_nettype none
interface wsi_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [9:0]         point_index;
  logic [2:0]         joint_index;
  logic signed [31:0] waypoint_value;
  logic [31:0]        query_time;

  modport source(output valid, opcode, point_index, joint_index, waypoint_value, query_time,
                 input ready);
  modport sink(input valid, opcode, point_index, joint_index, waypoint_value, query_time,
               output ready);
endinterface
`default_nettype wire

/* design/wsi_out_if.sv */
`default_nettype none
interface wsi_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         joint_number;
  logic signed [31:0] position;
  logic               last;
  logic               saturated;

  modport source(output valid, joint_number, position, last, saturated, input ready);
  modport sink(input valid, joint_number, position, last, saturated, output ready);
endinterface
`default_nettype wire

/* design/wsi_ram.sv */
`default_nettype none
module wsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/wsi_div.sv */
`default_nettype none
module wsi_div #(
  parameter int IB = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire wsi_pkg::item_t        in_item,
  input  wire logic [IB+31:0]        in_s,
  input  wire logic [31:0]           in_t,
  output logic                       out_valid,
  output wsi_pkg::item_t             out_item,
  output logic [IB+15:0]             out_quot
);

  localparam int QB = IB + 16;

  logic [31:0]    rem_r [QB];
  logic [QB-1:0]  dig_r [QB];
  logic [QB-1:0]  quo_r [QB];
  logic [QB-1:0]  vld_r;
  wsi_pkg::item_t item_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [31:0]    rem_in;
    logic [QB-1:0]  dig_in;
    logic [QB-1:0]  quo_in;
    logic           v_in;
    wsi_pkg::item_t it_in;
    logic [32:0]    trial;
    logic           ge;

    if (k == 0) begin : g_first
      // quotient fits QB bits, so the top of the dividend starts below the divisor
      assign rem_in = in_s[IB+31:IB];
      assign dig_in = {in_s[IB-1:0], 16'h0000};
      assign quo_in = '0;
      assign v_in   = in_valid;
      assign it_in  = in_item;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dig_in = dig_r[k-1];
      assign quo_in = quo_r[k-1];
      assign v_in   = vld_r[k-1];
      assign it_in  = item_r[k-1];
    end

    assign trial = {rem_in, dig_in[QB-1]};
    assign ge    = trial >= {1'b0, in_t};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 32'(trial - {1'b0, in_t}) : trial[31:0];
        dig_r[k]  <= {dig_in[QB-2:0], 1'b0};
        quo_r[k]  <= {quo_in[QB-2:0], ge};
        item_r[k] <= it_in;
      end
    end
  end

  assign out_valid = vld_r[QB-1];
  assign out_item  = item_r[QB-1];
  assign out_quot  = quo_r[QB-1];

endmodule
`default_nettype wire

/* design/waypoint_spline_interpolator_unit.sv */
// Pipeline: time scaling, then the time-to-segment divider, which retires one bit per
//   stage, then square, cube, joint sequencer, memory read, weighted terms and output.
// Sequencing: a load passes the joint sequencer as a single item; an evaluate holds it
//   until every joint in use is read, each joint taking one read of the four memory copies.
// Reset: synchronous, active low. Registers return to 1, 2, 1 and the waypoint store is
//   swept to zero, all JOINT_SLOTS * MAX_POINTS entries (8192 by default), with input held off.
`default_nettype none
module waypoint_spline_interpolator_unit #(
  parameter int JOINT_SLOTS = 8,
  parameter int MAX_POINTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wsi_in_if.sink           in_if,
  wsi_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int IB    = $clog2(MAX_POINTS);
  localparam int QB    = IB + 16;
  localparam int DEPTH = JOINT_SLOTS * MAX_POINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int JCAP  = (JOINT_SLOTS < 8) ? JOINT_SLOTS : 8;
  localparam int WW    = wsi_pkg::WGT_W;
  localparam int PRW   = WW + 33;

  // ---------------- configuration ----------------
  logic [31:0] tot_time_r;
  logic [10:0] pts_r;
  logic [3:0]  jnts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_time_r <= 32'd1;
      pts_r      <= 11'd2;
      jnts_r     <= 4'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        wsi_pkg::REG_TOTAL_TIME:    tot_time_r <= pwdata;
        wsi_pkg::REG_POINTS_IN_USE: pts_r      <= pwdata[10:0];
        wsi_pkg::REG_JOINTS_IN_USE: jnts_r     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wsi_pkg::REG_TOTAL_TIME:    prdata = tot_time_r;
      wsi_pkg::REG_POINTS_IN_USE: prdata = {21'd0, pts_r};
      wsi_pkg::REG_JOINTS_IN_USE: prdata = {28'd0, jnts_r};
      default:                    prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  logic [31:0]   tdiv;
  logic [16:0]   p_ext;
  logic [16:0]   pc;
  logic [IB-1:0] pm1;
  logic [3:0]    jc;
  logic [2:0]    jlast;

  always_comb begin
    tdiv  = (tot_time_r == 32'd0) ? 32'd1 : tot_time_r;
    p_ext = 17'(pts_r);
    if (p_ext < 17'd2) begin
      pc = 17'd2;
    end else if (p_ext > 17'(MAX_POINTS)) begin
      pc = 17'(MAX_POINTS);
    end else begin
      pc = p_ext;
    end
    pm1 = IB'(pc - 17'd1);
    if (jnts_r == 4'd0) begin
      jc = 4'd1;
    end else if (jnts_r > 4'(JCAP)) begin
      jc = 4'(JCAP);
    end else begin
      jc = jnts_r;
    end
    jlast = 3'(jc - 4'd1);
  end

  // ---------------- store clearing sweep ----------------
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------- flow control ----------------
  logic            out_valid_r;
  logic            adv;
  logic            en_up;
  logic            e_valid_r;
  logic            e_done;
  logic [2:0]      j_r;
  wsi_pkg::item_t  e_item_r;

  assign adv    = !out_valid_r || out_if.ready;
  assign e_done = (e_item_r.op == wsi_pkg::OP_LOAD) || (j_r == jlast);
  assign en_up  = adv && (!e_valid_r || e_done);
  assign in_if.ready = !clr_busy_r && en_up;

  // ---------------- stage A: time scaling ----------------
  logic            a_valid_r;
  wsi_pkg::item_t  a_item_r;
  wsi_pkg::item_t  a_item_nxt;
  logic [IB+31:0]  a_s_r;

  always_comb begin
    a_item_nxt.op       = wsi_pkg::opcode_t'(in_if.opcode);
    a_item_nxt.point    = in_if.point_index;
    a_item_nxt.joint    = in_if.joint_index;
    a_item_nxt.value    = in_if.waypoint_value;
    a_item_nxt.zero     = (in_if.query_time == 32'd0);
    a_item_nxt.past_end = (in_if.query_time >= tdiv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en_up) begin
      a_valid_r <= in_if.valid && !clr_busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_up) begin
      a_item_r <= a_item_nxt;
      a_s_r    <= (IB+32)'(in_if.query_time) * (IB+32)'(pm1);
    end
  end

  // ---------------- divider: index and fraction ----------------
  logic           d_valid;
  wsi_pkg::item_t d_item;
  logic [QB-1:0]  d_quot;

  wsi_div #(.IB(IB)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en_up),
    .in_valid  (a_valid_r),
    .in_item   (a_item_r),
    .in_s      (a_s_r),
    .in_t      (tdiv),
    .out_valid (d_valid),
    .out_item  (d_item),
    .out_quot  (d_quot)
  );

  // ---------------- W1: square ----------------
  logic            w1_valid_r;
  wsi_pkg::item_t  w1_item_r;
  logic [IB-1:0]   w1_idx_r;
  logic [IB-1:0]   w1_pt_r;
  logic [15:0]     w1_frac_r;
  logic [31:0]     w1_x2_r;
  logic            w1_exact_r;
  logic [IB-1:0]   d_idx;
  logic [15:0]     d_frac;

  assign d_idx  = d_quot[QB-1:16];
  assign d_frac = d_quot[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_valid_r <= 1'b0;
    end else if (en_up) begin
      w1_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_up) begin
      w1_item_r  <= d_item;
      w1_idx_r   <= d_idx;
      w1_frac_r  <= d_frac;
      w1_x2_r    <= 32'(d_frac) * 32'(d_frac);
      w1_exact_r <= d_item.zero || d_item.past_end || (d_frac == 16'd0);
      w1_pt_r    <= d_item.zero ? '0 : (d_item.past_end ? pm1 : d_idx);
    end
  end

  // ---------------- W2: cube ----------------
  logic            w2_valid_r;
  wsi_pkg::item_t  w2_item_r;
  logic [IB-1:0]   w2_idx_r;
  logic [IB-1:0]   w2_pt_r;
  logic [15:0]     w2_frac_r;
  logic [31:0]     w2_x2_r;
  logic [47:0]     w2_x3_r;
  logic            w2_exact_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w2_valid_r <= 1'b0;
    end else if (en_up) begin
      w2_valid_r <= w1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_up) begin
      w2_item_r  <= w1_item_r;
      w2_idx_r   <= w1_idx_r;
      w2_pt_r    <= w1_pt_r;
      w2_frac_r  <= w1_frac_r;
      w2_x2_r    <= w1_x2_r;
      w2_x3_r    <= 48'(w1_x2_r) * 48'(w1_frac_r);
      w2_exact_r <= w1_exact_r;
    end
  end

  // ---------------- W3: Hermite weights and base addresses ----------------
  logic signed [50:0] x3s, x2s16, xs32, h00, h01, h10, h11;
  logic signed [WW-1:0] w00_nxt, w01_nxt, w10_nxt, w11_nxt;
  logic [IB-1:0] ib_pt, i1_pt, i2_pt;
  logic [AW-1:0] a0_nxt, a1_nxt, ab_nxt, a2_nxt;
  logic          ld_ok_nxt;

  always_comb begin
    x3s   = $signed({3'b000, w2_x3_r});
    x2s16 = $signed({3'b000, w2_x2_r, 16'h0000});
    xs32  = $signed({3'b000, w2_frac_r, 32'h0000_0000});
    h00   = (x3s <<< 1) - x2s16 - (x2s16 <<< 1) + (51'sd1 <<< 48);
    h01   = (51'sd1 <<< 48) - h00;
    h10   = x3s - (x2s16 <<< 1) + xs32;
    h11   = x3s - x2s16;
    // round half up, tangent terms carry the extra halving
    w00_nxt = WW'((h00 + (51'sd1 <<< 23)) >>> 24);
    w01_nxt = WW'((h01 + (51'sd1 <<< 23)) >>> 24);
    w10_nxt = WW'((h10 + (51'sd1 <<< 24)) >>> 25);
    w11_nxt = WW'((h11 + (51'sd1 <<< 24)) >>> 25);

    ib_pt = (w2_idx_r == '0) ? '0 : IB'(w2_idx_r - IB'(1));
    i1_pt = IB'(w2_idx_r + IB'(1));
    i2_pt = (i1_pt == pm1) ? i1_pt : IB'(w2_idx_r + IB'(2));

    ld_ok_nxt = ({22'd0, w2_item_r.point} < 32'(MAX_POINTS)) &&
                ({29'd0, w2_item_r.joint} < 32'(JOINT_SLOTS));
    if (w2_item_r.op == wsi_pkg::OP_LOAD) begin
      a0_nxt = AW'(AW'(w2_item_r.point) * AW'(JOINT_SLOTS) + AW'(w2_item_r.joint));
    end else begin
      a0_nxt = AW'(AW'(w2_pt_r) * AW'(JOINT_SLOTS));
    end
    a1_nxt = AW'(AW'(i1_pt) * AW'(JOINT_SLOTS));
    ab_nxt = AW'(AW'(ib_pt) * AW'(JOINT_SLOTS));
    a2_nxt = AW'(AW'(i2_pt) * AW'(JOINT_SLOTS));
  end

  // ---------------- E: joint sequencer ----------------
  logic                 e_exact_r;
  logic                 e_ld_ok_r;
  logic [AW-1:0]        e_a0_r, e_a1_r, e_ab_r, e_a2_r;
  logic signed [WW-1:0] e_w00_r, e_w01_r, e_w10_r, e_w11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      j_r       <= 3'd0;
    end else if (en_up) begin
      e_valid_r <= w2_valid_r;
      j_r       <= 3'd0;
    end else if (adv && e_valid_r) begin
      j_r <= j_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_up) begin
      e_item_r  <= w2_item_r;
      e_exact_r <= w2_exact_r;
      e_ld_ok_r <= ld_ok_nxt;
      e_a0_r    <= a0_nxt;
      e_a1_r    <= a1_nxt;
      e_ab_r    <= ab_nxt;
      e_a2_r    <= a2_nxt;
      e_w00_r   <= w00_nxt;
      e_w01_r   <= w01_nxt;
      e_w10_r   <= w10_nxt;
      e_w11_r   <= w11_nxt;
    end
  end

  // ---------------- waypoint store, one copy per read tap ----------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   rd0, rd1, rdb, rd2;

  assign ram_we    = clr_busy_r ||
                     (adv && e_valid_r && (e_item_r.op == wsi_pkg::OP_LOAD) && e_ld_ok_r);
  assign ram_waddr = clr_busy_r ? clr_addr_r : e_a0_r;
  assign ram_wdata = clr_busy_r ? 32'd0 : e_item_r.value;

  wsi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_p0 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(adv), .raddr(AW'(e_a0_r + AW'(j_r))), .rdata(rd0)
  );
  wsi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_p1 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(adv), .raddr(AW'(e_a1_r + AW'(j_r))), .rdata(rd1)
  );
  wsi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_pb (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(adv), .raddr(AW'(e_ab_r + AW'(j_r))), .rdata(rdb)
  );
  wsi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_p2 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(adv), .raddr(AW'(e_a2_r + AW'(j_r))), .rdata(rd2)
  );

  // ---------------- R: read data lines up with its joint ----------------
  logic                 r_valid_r;
  logic [2:0]           r_j_r;
  logic                 r_last_r;
  logic                 r_exact_r;
  logic signed [WW-1:0] r_w00_r, r_w01_r, r_w10_r, r_w11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
    end else if (adv) begin
      r_valid_r <= e_valid_r && (e_item_r.op == wsi_pkg::OP_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_j_r     <= j_r;
      r_last_r  <= (j_r == jlast);
      r_exact_r <= e_exact_r;
      r_w00_r   <= e_w00_r;
      r_w01_r   <= e_w01_r;
      r_w10_r   <= e_w10_r;
      r_w11_r   <= e_w11_r;
    end
  end

  // ---------------- M: weighted terms ----------------
  logic                  m_valid_r;
  logic [2:0]            m_j_r;
  logic                  m_last_r;
  logic                  m_exact_r;
  logic signed [31:0]    m_p0_r;
  logic signed [PRW-1:0] m_t0_r, m_t1_r, m_t2_r, m_t3_r;
  logic signed [32:0]    d_p1b, d_p20;

  assign d_p1b = $signed({rd1[31], rd1}) - $signed({rdb[31], rdb});
  assign d_p20 = $signed({rd2[31], rd2}) - $signed({rd0[31], rd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r <= r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_j_r     <= r_j_r;
      m_last_r  <= r_last_r;
      m_exact_r <= r_exact_r;
      m_p0_r    <= $signed(rd0);
      m_t0_r    <= PRW'(r_w00_r * $signed(rd0));
      m_t1_r    <= PRW'(r_w01_r * $signed(rd1));
      m_t2_r    <= PRW'(r_w10_r * d_p1b);
      m_t3_r    <= PRW'(r_w11_r * d_p20);
    end
  end

  // ---------------- output: sum, round, clip ----------------
  logic signed [PRW+1:0] acc;
  logic signed [PRW-23:0] acc_rnd;
  logic signed [31:0]    pos_nxt;
  logic                  sat_nxt;
  logic [2:0]            out_j_r;
  logic signed [31:0]    out_pos_r;
  logic                  out_last_r;
  logic                  out_sat_r;

  always_comb begin
    acc = (PRW+2)'(m_t0_r) + (PRW+2)'(m_t1_r) + (PRW+2)'(m_t2_r) + (PRW+2)'(m_t3_r);
    acc_rnd = (PRW-22)'((acc + ((PRW+2)'(1) <<< 23)) >>> 24);
    if (m_exact_r) begin
      pos_nxt = m_p0_r;
      sat_nxt = 1'b0;
    end else if (acc_rnd > (PRW-22)'(32'sh7fff_ffff)) begin
      pos_nxt = 32'sh7fff_ffff;
      sat_nxt = 1'b1;
    end else if (acc_rnd < (PRW-22)'(32'sh8000_0000)) begin
      pos_nxt = 32'sh8000_0000;
      sat_nxt = 1'b1;
    end else begin
      pos_nxt = 32'(acc_rnd);
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_j_r    <= m_j_r;
      out_pos_r  <= pos_nxt;
      out_last_r <= m_last_r;
      out_sat_r  <= sat_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.joint_number = out_j_r;
  assign out_if.position     = out_pos_r;
  assign out_if.last         = out_last_r;
  assign out_if.saturated    = out_sat_r;

  // ---------------- assertions ----------------
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_if.ready)
    else $error("input taken during store clear");

  a_joint_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (e_valid_r && (e_item_r.op == wsi_pkg::OP_EVAL)) |-> (j_r <= jlast))
    else $error("joint sequencer ran past last joint");

  a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_pos_r == 32'sh7fff_ffff || out_pos_r == 32'sh8000_0000))
    else $error("saturated beat not at a range limit");

endmodule
`default_nettype wire
